### hw/rtl/booke_tlb_translate_manage_assert.svh
// Assertion helpers for the translation table.
`ifndef BOOKE_TLB_TRANSLATE_MANAGE_ASSERT_SVH
`define BOOKE_TLB_TRANSLATE_MANAGE_ASSERT_SVH

// Consequent checked in the same cycle.
`define BTLB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("translation table check failed");

// Consequent checked in the cycle after the antecedent.
`define BTLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("translation table check failed");

`endif

### hw/rtl/btlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btlb_pkg;

  localparam int SETS0    = 32;
  localparam int WAYS0    = 4;
  localparam int ENTRIES1 = 16;

  localparam int DEPTH0 = SETS0 * WAYS0;
  localparam int TOTAL  = DEPTH0 + ENTRIES1;
  localparam int IDX0_W = (DEPTH0 > 1) ? $clog2(DEPTH0) : 1;
  localparam int IDX1_W = (ENTRIES1 > 1) ? $clog2(ENTRIES1) : 1;
  localparam int SCAN_W = $clog2(TOTAL + 1);
  localparam int WAY_W  = (WAYS0 > 1) ? $clog2(WAYS0) : 1;

  localparam int TAG_W  = 33;  // size, space, pid, epn
  localparam int DATA_W = 41;  // perms, attributes, ra page
  localparam int WORD_W = TAG_W + DATA_W;

  typedef enum logic [2:0] {
    OP_TRANSLATE = 3'd0,
    OP_WRITE     = 3'd1,
    OP_READ      = 3'd2,
    OP_SEARCH    = 3'd3,
    OP_INVAL     = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    K_TRANS,
    K_SEARCH,
    K_WRITE,
    K_READ,
    K_INV_ONE,
    K_INV_ALL,
    K_NOP
  } kind_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  // boot page in entry 0 of the fully associative array
  localparam logic [TAG_W-1:0]  BOOT_TAG  = {4'd1, 1'b0, 8'h00, 20'hfffff};
  localparam logic [DATA_W-1:0] BOOT_DATA = {6'b000111, 11'h008, 24'h0fffff};

  typedef struct packed {
    kind_t       kind;
    logic        sel_ok;
    logic [31:0] addr;
    logic        space;
    logic [7:0]  pid;
    logic [3:0]  access;
    logic        tsel;
    logic [3:0]  esel;
    logic [23:0] ra_page;
    logic [3:0]  size;
    logic [1:0]  flags;
    logic [10:0] attr;
    logic [5:0]  perms;
  } req_t;

  typedef struct packed {
    logic        valid;
    req_t        req;
  } fe_bk_t;

  typedef struct packed {
    logic        busy;
    logic        fin;
  } bk_stat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [35:0] real_addr;
    logic [3:0]  size_code;
    logic [10:0] attr;
    logic [1:0]  flags;
    logic        found_array;
    logic [3:0]  found_index;
    logic [19:0] ea_page;
    logic [7:0]  pid;
    logic        space;
    logic [5:0]  perms;
    logic [23:0] ra_page;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/booke_tlb_translate_manage.sv
`timescale 1ns / 1ps
`default_nettype none
`include "booke_tlb_translate_manage_assert.svh"

// Channel   Handshake           Payload
// request   push / full         opcode .. permissions (one port per field)
// result    pop / empty         status .. ra_page_out (one port per field)
// config    cfg_write           cfg_data -> high_ra_enable
//
// Translate and search scan the set-associative array then the fully
// associative one through one registered RAM read per cycle, stopping
// early on a hit. Write and read pass an access state, read then a
// read-wait state. Invalidate-all clears the unprotected valid bits from
// idle; single invalidate scans only the selected array.
// Reset is synchronous: valid bits clear at once, the boot page is live in
// entry 0 of the fully associative array, no clearing pass.
// A two-entry request queue and a result register let either side stall.
module booke_tlb_translate_manage (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [31:0] addr,
  input  logic        space,
  input  logic [7:0]  pid,
  input  logic [3:0]  access,
  input  logic        tlb_select,
  input  logic [3:0]  entry_select,
  input  logic [23:0] ra_page,
  input  logic [3:0]  size_code,
  input  logic [1:0]  entry_flags,
  input  logic [10:0] page_attributes,
  input  logic [5:0]  permissions,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  status,
  output logic [35:0] real_addr,
  output logic [3:0]  size_code_out,
  output logic [10:0] attributes_out,
  output logic [1:0]  flags_out,
  output logic        found_array,
  output logic [3:0]  found_index,
  output logic [19:0] ea_page_out,
  output logic [7:0]  pid_out,
  output logic        space_out,
  output logic [5:0]  permissions_out,
  output logic [23:0] ra_page_out,
  input  logic        cfg_write,
  input  logic        cfg_data
);
  import btlb_pkg::*;

  logic     high_ra_enable;
  fe_bk_t   fe_q;
  logic     fe_pop;
  res_t     res;
  logic     res_valid;
  bk_stat_t bk_stat;

  // upper four real address bits enable
  always_ff @(posedge clk) begin
    if (rst) begin
      high_ra_enable <= 1'b0;
    end else if (cfg_write) begin
      high_ra_enable <= cfg_data;
    end
  end

  // front: accepts and classifies requests into a short queue
  btlb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .opcode          (opcode),
    .addr            (addr),
    .space           (space),
    .pid             (pid),
    .access          (access),
    .tlb_select      (tlb_select),
    .entry_select    (entry_select),
    .ra_page         (ra_page),
    .size_code       (size_code),
    .entry_flags     (entry_flags),
    .page_attributes (page_attributes),
    .permissions     (permissions),
    .q               (fe_q),
    .q_pop           (fe_pop)
  );

  // back: arrays, scan sequencer and result register
  btlb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hra       (high_ra_enable),
    .q         (fe_q),
    .q_pop     (fe_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop),
    .stat      (bk_stat)
  );

  assign empty           = !res_valid;
  assign status          = res.status;
  assign real_addr       = res.real_addr;
  assign size_code_out   = res.size_code;
  assign attributes_out  = res.attr;
  assign flags_out       = res.flags;
  assign found_array     = res.found_array;
  assign found_index     = res.found_index;
  assign ea_page_out     = res.ea_page;
  assign pid_out         = res.pid;
  assign space_out       = res.space;
  assign permissions_out = res.perms;
  assign ra_page_out     = res.ra_page;

  // an accepted request is visible to the back next cycle
  `BTLB_ASSERT_NEXT(a_push_queued, clk, rst, push && !full, fe_q.valid)
  // a finished request lands in the result register
  `BTLB_ASSERT_NEXT(a_fin_shown, clk, rst, bk_stat.fin, !empty)
  // a taken result frees the register unless a new one lands
  `BTLB_ASSERT_NEXT(a_pop_frees, clk, rst, pop && !empty && !bk_stat.fin, empty)

endmodule

`default_nettype wire

### hw/rtl/btlb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module btlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/btlb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module btlb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          opcode,
  input  logic [31:0]         addr,
  input  logic                space,
  input  logic [7:0]          pid,
  input  logic [3:0]          access,
  input  logic                tlb_select,
  input  logic [3:0]          entry_select,
  input  logic [23:0]         ra_page,
  input  logic [3:0]          size_code,
  input  logic [1:0]          entry_flags,
  input  logic [10:0]         page_attributes,
  input  logic [5:0]          permissions,
  output btlb_pkg::fe_bk_t    q,
  input  logic                q_pop
);
  import btlb_pkg::*;

  req_t       req_in;
  req_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push_ok;
  logic       pop_ok;

  // classify the request
  always_comb begin
    req_in.addr    = addr;
    req_in.space   = space;
    req_in.pid     = pid;
    req_in.access  = access;
    req_in.tsel    = tlb_select;
    req_in.esel    = entry_select;
    req_in.ra_page = ra_page;
    req_in.size    = size_code;
    req_in.flags   = entry_flags;
    req_in.attr    = page_attributes;
    req_in.perms   = permissions;
    req_in.sel_ok  = tlb_select ? (32'(entry_select) < ENTRIES1)
                                : (32'(entry_select) < WAYS0);
    unique case (opcode)
      OP_TRANSLATE: req_in.kind = K_TRANS;
      OP_WRITE:     req_in.kind = K_WRITE;
      OP_READ:      req_in.kind = K_READ;
      OP_SEARCH:    req_in.kind = K_SEARCH;
      OP_INVAL:     req_in.kind = addr[2] ? K_INV_ALL : K_INV_ONE;
      default:      req_in.kind = K_NOP;
    endcase
  end

  assign full    = (cnt == 2'd2);
  assign push_ok = push && !full;
  assign pop_ok  = q_pop && q.valid;
  assign q.valid = (cnt != 2'd0);
  assign q.req   = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push_ok) begin
        wp <= ~wp;
      end
      if (pop_ok) begin
        rp <= ~rp;
      end
      if (push_ok && !pop_ok) begin
        cnt <= cnt + 2'd1;
      end else if (!push_ok && pop_ok) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wp] <= req_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/btlb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module btlb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                hra,
  input  btlb_pkg::fe_bk_t    q,
  output logic                q_pop,
  output btlb_pkg::res_t      res,
  output logic                res_valid,
  input  logic                res_pop,
  output btlb_pkg::bk_stat_t  stat
);
  import btlb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ACCESS = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  function automatic logic [31:0] offset_mask(input logic [3:0] sz);
    logic [5:0]  sh;
    logic [31:0] m;
    sh = 6'd10 + {1'b0, sz, 1'b0};
    for (int b = 0; b < 32; b++) begin
      m[b] = (6'(b) < sh);
    end
    return m;
  endfunction

  state_t              state;
  req_t                cur;
  res_t                pend;
  logic                v0 [DEPTH0];
  logic                v1 [ENTRIES1];
  logic                p1 [ENTRIES1];
  logic                boot1;
  logic [SCAN_W-1:0]   scan_idx;
  logic [SCAN_W-1:0]   scan_end;
  logic [WAY_W-1:0]    way;
  logic                chk;
  logic                lk_arr;
  logic [IDX0_W-1:0]   lk_i0;
  logic [IDX1_W-1:0]   lk_i1;
  logic [WAY_W-1:0]    lk_way;
  logic                rd_boot;

  logic                issuing;
  logic                in1;
  logic [IDX1_W-1:0]   sc_i1;
  logic [IDX0_W-1:0]   acc_i0;
  logic [IDX1_W-1:0]   acc_i1;
  logic                ram0_we;
  logic                ram1_we;
  logic [IDX0_W-1:0]   ram0_raddr;
  logic [IDX1_W-1:0]   ram1_raddr;
  logic [WORD_W-1:0]   wr_word;
  logic [WORD_W-1:0]   ram0_rdata;
  logic [WORD_W-1:0]   ram1_rdata;
  logic [WORD_W-1:0]   word;
  logic [19:0]         t_epn;
  logic [7:0]          t_pid;
  logic                t_space;
  logic [3:0]          t_size;
  logic [23:0]         d_ra;
  logic [10:0]         d_attr;
  logic [5:0]          d_perm;
  logic                lk_valid;
  logic                lk_prot;
  logic [31:0]         pmask;
  logic                pm;
  logic                km;
  logic [2:0]          rwx;
  logic [5:0]          need;
  res_t                ent;
  res_t                hit_res;
  res_t                st_res;
  res_t                miss_res;
  logic                fin_fire;

  assign issuing  = (state == S_SCAN) && (scan_idx != scan_end);
  assign in1      = (scan_idx >= SCAN_W'(DEPTH0));
  assign sc_i1    = IDX1_W'(scan_idx - SCAN_W'(DEPTH0));
  // set = page mod SETS0 (power of two)
  assign acc_i0   = IDX0_W'((32'(cur.addr[31:12]) % SETS0) * WAYS0 + 32'(cur.esel));
  assign acc_i1   = IDX1_W'(cur.esel);
  assign fin_fire = (state == S_FIN) && (!res_valid || res_pop);
  assign q_pop    = (state == S_IDLE) && q.valid;

  assign stat.busy = (state != S_IDLE);
  assign stat.fin  = fin_fire;

  // memory ports
  always_comb begin
    ram0_we    = (state == S_ACCESS) && (cur.kind == K_WRITE) && !cur.tsel;
    ram1_we    = (state == S_ACCESS) && (cur.kind == K_WRITE) && cur.tsel;
    ram0_raddr = (state == S_ACCESS) ? acc_i0 : scan_idx[IDX0_W-1:0];
    ram1_raddr = (state == S_ACCESS) ? acc_i1 : sc_i1;
    wr_word    = {cur.perms, cur.attr,
                  (hra ? cur.ra_page[23:20] : 4'h0), cur.ra_page[19:0],
                  cur.size, cur.space, cur.pid, cur.addr[31:12]};
  end

  btlb_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH0)) u_ram0 (
    .clk   (clk),
    .we    (ram0_we),
    .waddr (acc_i0),
    .wdata (wr_word),
    .raddr (ram0_raddr),
    .rdata (ram0_rdata)
  );

  btlb_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES1)) u_ram1 (
    .clk   (clk),
    .we    (ram1_we),
    .waddr (acc_i1),
    .wdata (wr_word),
    .raddr (ram1_raddr),
    .rdata (ram1_rdata)
  );

  // looked-up entry and its match
  always_comb begin
    if (lk_arr) begin
      word = rd_boot ? {BOOT_DATA, BOOT_TAG} : ram1_rdata;
    end else begin
      word = ram0_rdata;
    end
    t_epn    = word[19:0];
    t_pid    = word[27:20];
    t_space  = word[28];
    t_size   = word[32:29];
    d_ra     = word[56:33];
    d_attr   = word[67:57];
    d_perm   = word[73:68];
    lk_valid = lk_arr ? v1[lk_i1] : v0[lk_i0];
    lk_prot  = lk_arr ? p1[lk_i1] : 1'b0;
    pmask    = offset_mask(t_size);
    pm       = ((cur.addr & ~pmask) == {t_epn, 12'h000});
    km       = lk_valid && (t_space == cur.space) && (t_pid == cur.pid) && pm;

    ent           = '0;
    ent.status    = ST_OK;
    ent.size_code = t_size;
    ent.attr      = d_attr;
    ent.flags     = {lk_prot, lk_valid};
    ent.ea_page   = t_epn;
    ent.pid       = t_pid;
    ent.space     = t_space;
    ent.perms     = d_perm;
    ent.ra_page   = {(hra ? d_ra[23:20] : 4'h0), d_ra[19:0]};

    rwx  = cur.access[2:0];
    need = cur.access[3] ? {rwx, 3'b000} : {3'b000, rwx};

    st_res          = '0;
    miss_res        = '0;
    miss_res.status = ST_MISS;
    hit_res = ent;
    hit_res.found_array = lk_arr;
    hit_res.found_index = lk_arr ? 4'(lk_i1) : 4'(lk_way);
    if (cur.kind == K_TRANS) begin
      if ((d_perm & need) != need) begin
        hit_res = '0;
        hit_res.status = rwx[0] ? ST_EXEC : (rwx[1] ? ST_WRITE : ST_READ);
      end else begin
        hit_res.real_addr = {d_ra, 12'h000} + {4'h0, cur.addr & pmask};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      chk       <= 1'b0;
      boot1     <= 1'b1;
      for (int i = 0; i < DEPTH0; i++) begin
        v0[i] <= 1'b0;
      end
      for (int i = 0; i < ENTRIES1; i++) begin
        v1[i] <= (i == 0);
        p1[i] <= (i == 0);
      end
    end else begin
      if (fin_fire) begin
        res_valid <= 1'b1;
        res       <= pend;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q.valid) begin
            cur      <= q.req;
            way      <= '0;
            chk      <= 1'b0;
            // single invalidate scans only the selected array
            scan_idx <= (q.req.kind == K_INV_ONE && q.req.addr[3]) ?
                        SCAN_W'(DEPTH0) : '0;
            scan_end <= (q.req.kind == K_INV_ONE && !q.req.addr[3]) ?
                        SCAN_W'(DEPTH0) : SCAN_W'(TOTAL);
            case (q.req.kind) inside
              K_TRANS, K_SEARCH, K_INV_ONE: begin
                state <= S_SCAN;
              end
              K_INV_ALL: begin
                if (q.req.addr[3]) begin
                  for (int i = 0; i < ENTRIES1; i++) begin
                    v1[i] <= v1[i] & p1[i];
                  end
                end else begin
                  for (int i = 0; i < DEPTH0; i++) begin
                    v0[i] <= 1'b0;
                  end
                end
                pend  <= st_res;
                state <= S_FIN;
              end
              K_WRITE, K_READ: begin
                if (!q.req.sel_ok) begin
                  pend  <= miss_res;
                  state <= S_FIN;
                end else begin
                  state <= S_ACCESS;
                end
              end
              default: begin
                pend  <= st_res;
                state <= S_FIN;
              end
            endcase
          end
        end

        S_ACCESS: begin
          lk_arr  <= cur.tsel;
          lk_i0   <= acc_i0;
          lk_i1   <= acc_i1;
          rd_boot <= cur.tsel && (acc_i1 == '0) && boot1;
          if (cur.kind == K_WRITE) begin
            if (cur.tsel) begin
              v1[acc_i1] <= cur.flags[0];
              p1[acc_i1] <= cur.flags[1];
              if (acc_i1 == '0) begin
                boot1 <= 1'b0;
              end
            end else begin
              v0[acc_i0] <= cur.flags[0];
            end
            pend  <= st_res;
            state <= S_FIN;
          end else begin
            state <= S_RDWAIT;
          end
        end

        S_RDWAIT: begin
          pend  <= ent;
          state <= S_FIN;
        end

        // issue one read a cycle, check the one issued last cycle
        S_SCAN: begin
          if (issuing) begin
            scan_idx <= scan_idx + 1'b1;
            way      <= (way == WAY_W'(WAYS0 - 1)) ? '0 : way + 1'b1;
            lk_arr   <= in1;
            lk_i0    <= scan_idx[IDX0_W-1:0];
            lk_i1    <= sc_i1;
            lk_way   <= way;
            rd_boot  <= in1 && (sc_i1 == '0) && boot1;
            chk      <= 1'b1;
          end else begin
            chk <= 1'b0;
          end
          if (chk) begin
            if (cur.kind == K_INV_ONE) begin
              if (lk_valid && pm && !lk_prot) begin
                if (lk_arr) begin
                  v1[lk_i1] <= 1'b0;
                end else begin
                  v0[lk_i0] <= 1'b0;
                end
              end
            end else if (km) begin
              pend  <= hit_res;
              state <= S_FIN;
            end
          end
          if (!issuing && !chk) begin
            pend  <= (cur.kind == K_INV_ONE) ? st_res : miss_res;
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (fin_fire) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/tb_booke_tlb_translate_manage.sv
`timescale 1ns / 1ps

module tb_booke_tlb_translate_manage;
  import btlb_pkg::*;

  // opcodes outside the defined set: block must answer all-zero and change nothing
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  // one request as the sender sees it
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic        space;
    logic [7:0]  pid;
    logic [3:0]  access;
    logic        tsel;
    logic [3:0]  esel;
    logic [23:0] ra;
    logic [3:0]  size;
    logic [1:0]  flags;
    logic [10:0] attr;
    logic [5:0]  perms;
  } tlb_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  // request fields, driven from drv_req
  logic [2:0]  opcode = '0;
  logic [31:0] addr = '0;
  logic        space = 1'b0;
  logic [7:0]  pid = '0;
  logic [3:0]  access = '0;
  logic        tlb_select = 1'b0;
  logic [3:0]  entry_select = '0;
  logic [23:0] ra_page = '0;
  logic [3:0]  size_code = 4'd1;
  logic [1:0]  entry_flags = '0;
  logic [10:0] page_attributes = '0;
  logic [5:0]  permissions = '0;

  logic [2:0]  status;
  logic [35:0] real_addr;
  logic [3:0]  size_code_out;
  logic [10:0] attributes_out;
  logic [1:0]  flags_out;
  logic        found_array;
  logic [3:0]  found_index;
  logic [19:0] ea_page_out;
  logic [7:0]  pid_out;
  logic        space_out;
  logic [5:0]  permissions_out;
  logic [23:0] ra_page_out;

  booke_tlb_translate_manage u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .addr(addr), .space(space), .pid(pid), .access(access),
    .tlb_select(tlb_select), .entry_select(entry_select), .ra_page(ra_page),
    .size_code(size_code), .entry_flags(entry_flags),
    .page_attributes(page_attributes), .permissions(permissions),
    .pop(pop), .empty(empty),
    .status(status), .real_addr(real_addr), .size_code_out(size_code_out),
    .attributes_out(attributes_out), .flags_out(flags_out),
    .found_array(found_array), .found_index(found_index),
    .ea_page_out(ea_page_out), .pid_out(pid_out), .space_out(space_out),
    .permissions_out(permissions_out), .ra_page_out(ra_page_out),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow of the table. Tag layout: epn[19:0] pid[27:20] space[28]
  // size[32:29] valid[33] protect[34]. Data: ra[23:0] attr[34:24] perms[40:35].
  logic [34:0] shadow_tag0 [DEPTH0];
  logic [40:0] shadow_dat0 [DEPTH0];
  logic [34:0] shadow_tag1 [ENTRIES1];
  logic [40:0] shadow_dat1 [ENTRIES1];
  logic        shadow_hra = 1'b0;

  tlb_req_t req_backlog [$];    // requests not yet offered
  res_t     expected_resp [$];  // responses owed by the block, oldest first
  tlb_req_t drv_req;
  int       mismatches = 0;
  bit       quiet = 1'b0;       // no idling on either side while set

  // generator-side bookkeeping: which entries hold written data
  bit       gen_w0 [DEPTH0];
  bit       gen_w1 [ENTRIES1];
  int       gen_w0_list [$];
  int       gen_w1_list [$];
  logic [19:0] pool_page [8];
  logic [7:0]  pool_pid [4];

  function automatic logic [63:0] page_mask(logic [34:0] t);
    return (64'd1 << (10 + 2 * t[32:29])) - 64'd1;
  endfunction

  function automatic bit page_hit(logic [34:0] t, logic [31:0] a);
    return ({32'd0, a} & ~page_mask(t)) == {32'd0, t[19:0], 12'd0};
  endfunction

  function automatic bit key_hit(logic [34:0] t, tlb_req_t rq);
    return t[33] && t[28] == rq.space && t[27:20] == rq.pid && page_hit(t, rq.addr);
  endfunction

  function automatic void entry_fields(ref res_t r, input logic [34:0] t,
                                       input logic [40:0] d);
    r.size_code = t[32:29];
    r.attr      = d[34:24];
    r.flags     = {t[34], t[33]};
    r.ea_page   = t[19:0];
    r.pid       = t[27:20];
    r.space     = t[28];
    r.perms     = d[40:35];
    r.ra_page   = shadow_hra ? d[23:0] : {4'd0, d[19:0]};
  endfunction

  // Computes the response to one request and applies its side effects.
  function automatic res_t tlb_predict(tlb_req_t rq);
    res_t r;
    int i, hit_arr, hit_idx, slot;
    bit found;
    logic [34:0] t;
    logic [40:0] d;
    logic [2:0] rwx;
    logic [5:0] need;
    logic [63:0] ra_full;
    r = '0;
    found = 1'b0;
    hit_arr = 0;
    hit_idx = 0;
    slot = int'(rq.addr[31:12]) % SETS0 * WAYS0 + int'(rq.esel);
    case (rq.op)
      OP_TRANSLATE, OP_SEARCH: begin
        for (i = 0; i < DEPTH0; i++)
          if (!found && key_hit(shadow_tag0[i], rq)) begin
            found = 1'b1; hit_arr = 0; hit_idx = i;
          end
        for (i = 0; i < ENTRIES1; i++)
          if (!found && key_hit(shadow_tag1[i], rq)) begin
            found = 1'b1; hit_arr = 1; hit_idx = i;
          end
        if (!found) begin
          r.status = ST_MISS;
        end else begin
          t = hit_arr ? shadow_tag1[hit_idx] : shadow_tag0[hit_idx];
          d = hit_arr ? shadow_dat1[hit_idx] : shadow_dat0[hit_idx];
          rwx = rq.access[2:0];
          // user mode checks the upper permission triplet
          need = rq.access[3] ? {rwx, 3'b000} : {3'b000, rwx};
          if (rq.op == OP_TRANSLATE && (d[40:35] & need) != need) begin
            r.status = rwx[0] ? ST_EXEC : rwx[1] ? ST_WRITE : ST_READ;
          end else begin
            if (rq.op == OP_TRANSLATE) begin
              ra_full = {28'd0, d[23:0], 12'd0} + ({32'd0, rq.addr} & page_mask(t));
              r.real_addr = ra_full[35:0];
            end
            entry_fields(r, t, d);
            r.found_array = hit_arr[0];
            r.found_index = hit_arr ? hit_idx[3:0] : 4'(hit_idx % WAYS0);
          end
        end
      end
      OP_WRITE, OP_READ: begin
        if ((rq.tsel == 1'b0 && rq.esel >= WAYS0) || (rq.tsel && rq.esel >= ENTRIES1)) begin
          r.status = ST_MISS;
        end else if (rq.op == OP_READ) begin
          if (rq.tsel) entry_fields(r, shadow_tag1[rq.esel], shadow_dat1[rq.esel]);
          else entry_fields(r, shadow_tag0[slot], shadow_dat0[slot]);
        end else begin
          t = {rq.tsel & rq.flags[1], rq.flags[0], rq.size, rq.space, rq.pid,
               rq.addr[31:12]};
          d = {rq.perms, rq.attr, shadow_hra ? rq.ra[23:20] : 4'd0, rq.ra[19:0]};
          if (rq.tsel) begin
            shadow_tag1[rq.esel] = t; shadow_dat1[rq.esel] = d;
          end else begin
            shadow_tag0[slot] = t; shadow_dat0[slot] = d;
          end
        end
      end
      OP_INVAL: begin
        // addr[3] picks the array, addr[2] means all; protected entries survive
        if (!rq.addr[3]) begin
          for (i = 0; i < DEPTH0; i++)
            if (rq.addr[2] || (shadow_tag0[i][33] && page_hit(shadow_tag0[i], rq.addr)))
              shadow_tag0[i][33] = 1'b0;
        end else begin
          for (i = 0; i < ENTRIES1; i++)
            if (!shadow_tag1[i][34] &&
                (rq.addr[2] || (shadow_tag1[i][33] && page_hit(shadow_tag1[i], rq.addr))))
              shadow_tag1[i][33] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Queues a request and tracks which entries now hold data.
  function automatic void send(tlb_req_t rq);
    int slot;
    slot = int'(rq.addr[31:12]) % SETS0 * WAYS0 + int'(rq.esel);
    if (rq.op == OP_WRITE) begin
      if (!rq.tsel && rq.esel < WAYS0 && !gen_w0[slot]) begin
        gen_w0[slot] = 1'b1; gen_w0_list.push_back(slot);
      end
      if (rq.tsel && !gen_w1[rq.esel]) begin
        gen_w1[rq.esel] = 1'b1; gen_w1_list.push_back(int'(rq.esel));
      end
    end
    req_backlog.push_back(rq);
  endfunction

  function automatic tlb_req_t blank(logic [2:0] op);
    tlb_req_t rq;
    rq = '0;
    rq.op = op;
    rq.size = 4'd1;
    return rq;
  endfunction

  // Read of an entry known to hold data, or an out-of-range way now and then.
  function automatic void aim_read(ref tlb_req_t rq);
    int k;
    if (!rq.tsel) begin
      if (gen_w0_list.size() == 0 || $urandom_range(9) == 0) begin
        rq.esel = 4'($urandom_range(WAYS0, 15));
      end else begin
        k = gen_w0_list[$urandom_range(gen_w0_list.size() - 1)];
        rq.addr[16:12] = 5'(k / WAYS0);
        rq.esel = 4'(k % WAYS0);
      end
    end else begin
      rq.esel = 4'(gen_w1_list[$urandom_range(gen_w1_list.size() - 1)]);
    end
  endfunction

  // Mostly well-formed traffic over a small pool of pages and pids so that
  // translates and searches hit; the rest is noise.
  function automatic tlb_req_t gen_request();
    tlb_req_t rq;
    int pick;
    logic [19:0] epn;
    rq.op = OP_TRANSLATE;
    rq.addr = $urandom;
    rq.space = 1'($urandom);
    rq.pid = 8'($urandom);
    rq.access = 4'($urandom);
    rq.tsel = 1'($urandom);
    rq.esel = 4'($urandom);
    rq.ra = 24'($urandom);
    rq.size = 4'($urandom_range(1, 11));
    rq.flags = 2'($urandom);
    rq.attr = 11'($urandom);
    rq.perms = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 85) begin
      rq.addr[31:12] = pool_page[$urandom_range(7)];
      rq.pid = pool_pid[$urandom_range(3)];
    end
    if (pick < 30) begin
      rq.op = OP_TRANSLATE;
    end else if (pick < 40) begin
      rq.op = OP_SEARCH;
    end else if (pick < 62) begin
      rq.op = OP_WRITE;
      if ($urandom_range(3) != 0) rq.size = 4'($urandom_range(1, 3));
      // clear epn bits below the page size so the entry can match
      epn = rq.addr[31:12] & ~20'((64'd1 << (2 * rq.size - 2)) - 1);
      rq.addr[31:12] = epn;
      if ($urandom_range(4) != 0) rq.flags[0] = 1'b1;
      if (!rq.tsel && $urandom_range(19) != 0) rq.esel = 4'($urandom_range(0, WAYS0 - 1));
    end else if (pick < 72) begin
      rq.op = OP_READ;
      aim_read(rq);
    end else if (pick < 78) begin
      rq.op = OP_INVAL;
      rq.addr[2] = ($urandom_range(9) == 0);
    end else if (pick < 81) begin
      rq.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end else begin
      rq.op = 3'($urandom_range(OP_TRANSLATE, OP_INVAL));
      if (rq.op == OP_READ) aim_read(rq);
      if (rq.op == OP_INVAL && $urandom_range(3) != 0) rq.addr[2] = 1'b0;
    end
    return rq;
  endfunction

  // Sender: predict at acceptance, then offer the next request or idle.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_resp.push_back(tlb_predict(drv_req));
      if (!(push && full)) begin
        if (req_backlog.size() > 0 && (quiet || $urandom_range(99) >= 19)) begin
          drv_req = req_backlog.pop_front();
          push            <= 1'b1;
          opcode          <= drv_req.op;
          addr            <= drv_req.addr;
          space           <= drv_req.space;
          pid             <= drv_req.pid;
          access          <= drv_req.access;
          tlb_select      <= drv_req.tsel;
          entry_select    <= drv_req.esel;
          ra_page         <= drv_req.ra;
          size_code       <= drv_req.size;
          entry_flags     <= drv_req.flags;
          page_attributes <= drv_req.attr;
          permissions     <= drv_req.perms;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each popped response with the oldest expectation.
  always @(posedge clk) begin
    res_t seen, want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = '{status, real_addr, size_code_out, attributes_out, flags_out,
                 found_array, found_index, ea_page_out, pid_out, space_out,
                 permissions_out, ra_page_out};
        if (expected_resp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", seen);
        end else begin
          want = expected_resp.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, seen);
          end
        end
      end
      pop <= quiet || ($urandom_range(99) >= 19);
    end
  end

  task automatic drain();
    while (req_backlog.size() > 0 || push || expected_resp.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_high_ra(bit v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    shadow_hra = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    tlb_req_t rq;
    int i, ph;
    for (i = 0; i < DEPTH0; i++) begin
      shadow_tag0[i] = '0; shadow_dat0[i] = '0; gen_w0[i] = 1'b0;
    end
    for (i = 0; i < ENTRIES1; i++) begin
      shadow_tag1[i] = '0; shadow_dat1[i] = '0; gen_w1[i] = 1'b0;
    end
    // boot page lives in entry 0 of the fully associative array
    shadow_tag1[0] = {1'b1, 1'b1, BOOT_TAG};
    shadow_dat1[0] = BOOT_DATA;
    gen_w1[0] = 1'b1;
    gen_w1_list.push_back(0);
    for (i = 0; i < 8; i++) pool_page[i] = 20'($urandom);
    pool_pid[0] = 8'h00;
    pool_pid[1] = 8'hff;
    pool_pid[2] = 8'($urandom);
    pool_pid[3] = 8'($urandom);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_high_ra(1'b0);

    // boot page: supervisor rwx passes; user exec, write, read fault in order
    rq = blank(OP_TRANSLATE); rq.addr = 32'hffff_f123; rq.access = 4'b0111; send(rq);
    rq.access = 4'b1001; send(rq);
    rq.access = 4'b1010; send(rq);
    rq.access = 4'b1100; send(rq);
    rq.access = 4'b1000; send(rq);  // no rwx requested: always passes
    rq.op = OP_SEARCH; send(rq);
    rq = blank(OP_READ); rq.tsel = 1'b1; send(rq);
    rq = blank(OP_TRANSLATE); rq.pid = 8'd5; send(rq);  // miss
    // extremes of the write fields other than the page size
    rq = blank(OP_WRITE); rq.addr = 32'hffff_ffff; rq.pid = 8'hff; rq.space = 1'b1;
    rq.esel = 4'd3; rq.flags = 2'b11; rq.ra = 24'hff_ffff; rq.attr = 11'h7ff;
    rq.perms = 6'h3f; send(rq);
    rq.op = OP_TRANSLATE; rq.access = 4'hf; send(rq);
    rq.op = OP_READ; send(rq);
    rq = blank(OP_WRITE); rq.esel = 4'd15; send(rq);  // way out of range
    rq.op = OP_READ; rq.esel = 4'd4; send(rq);
    // largest page in array 1 covers the whole space
    rq = blank(OP_WRITE); rq.tsel = 1'b1; rq.esel = 4'd15; rq.size = 4'd11;
    rq.flags = 2'b01; send(rq);
    rq = blank(OP_TRANSLATE); rq.addr = 32'h1234_5678; rq.access = 4'b0010; send(rq);
    rq.op = OP_SEARCH; send(rq);
    rq = blank(OP_INVAL); rq.addr = 32'h1234_5008; send(rq);  // single, array 1
    rq = blank(OP_TRANSLATE); rq.addr = 32'h1234_5678; send(rq);
    // protected entry survives invalidate-all of array 1
    rq = blank(OP_WRITE); rq.tsel = 1'b1; rq.esel = 4'd1; rq.addr = 32'h0040_0000;
    rq.size = 4'd2; rq.flags = 2'b11; rq.perms = 6'h07; send(rq);
    rq = blank(OP_INVAL); rq.addr = 32'h0000_000c; send(rq);
    rq = blank(OP_TRANSLATE); rq.addr = 32'h0040_0abc; rq.access = 4'b0100; send(rq);
    rq = blank(OP_INVAL); rq.addr = 32'h0000_0004; send(rq);  // all of array 0
    rq = blank(OP_TRANSLATE); rq.addr = 32'hffff_ffff; rq.space = 1'b1; rq.pid = 8'hff;
    send(rq);
    send(blank(OP_RSVD_LO));
    send(blank(OP_RSVD_HI));
    drain();

    // random phases; the sender waits out every response between them
    for (ph = 0; ph < 3; ph++) begin
      set_high_ra(ph != 1);
      quiet = (ph == 0);
      for (i = 0; i < 215; i++) send(gen_request());
      drain();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_resp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/btlb_pkg.sv
hw/rtl/btlb_ram.sv
hw/rtl/btlb_front.sv
hw/rtl/btlb_back.sv
hw/rtl/booke_tlb_translate_manage.sv
dv/tb_booke_tlb_translate_manage.sv
